FILE: rtl/wbf_pkg.sv
`default_nettype none
package wbf_pkg;

	localparam int LEN_W = 4;
	localparam int WORD_W = 64;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_START = 2'd2,
		CMD_TEXT  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_BAD_LEN = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	// control broadcast to every cell of the row
	typedef struct packed {
		logic flush;  // drop the hit carry
		logic scan;   // advance the hit carry by one cell
	} cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/wbf_cell.sv
`default_nettype none
module wbf_cell #(
	parameter int MAX_WORD_LEN = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire wbf_pkg::cell_ctrl_t       ctrl,
	input  wire logic                      enable,
	input  wire logic                      load,
	input  wire logic [8*MAX_WORD_LEN-1:0] load_word,
	input  wire logic [wbf_pkg::LEN_W-1:0] load_len,
	input  wire logic [8*MAX_WORD_LEN-1:0] window,
	input  wire logic [MAX_WORD_LEN-1:0]   reach,
	input  wire logic                      hit_in,
	output logic                           hit_out
);
	import wbf_pkg::*;

	localparam int WW = 8 * MAX_WORD_LEN;

	logic [WW-1:0]    word_q;
	logic [LEN_W-1:0] len_q;
	logic             hit_q;
	logic [WW-1:0]    tail;
	logic             reach_bit;
	logic             match;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_word;
			len_q  <= load_len;
		end
	end

	// newest len bytes of the window, and the reach bit len positions back
	always_comb begin
		tail      = '0;
		reach_bit = 1'b0;
		for (int l = 1; l <= MAX_WORD_LEN; l++) begin
			if (len_q == LEN_W'(l)) begin
				tail      = window >> (8 * (MAX_WORD_LEN - l));
				reach_bit = reach[l-1];
			end
		end
	end

	assign match = enable && reach_bit && (tail == word_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.flush) begin
			hit_q <= 1'b0;
		end else if (ctrl.scan) begin
			hit_q <= hit_in | match;
		end
	end

	assign hit_out = hit_q;

endmodule
`default_nettype wire

FILE: rtl/word_break_feasibility.sv
// Clear, add word and start text: one cycle each, result one cycle after accept.
// Text byte: no further request is taken until its result is posted; the match
// carry walks the row of word cells one cell per clock, then the finish state posts
// the result and updates the reach window once the output register can take it.
// Reset (arst_n low, asynchronous): empty dictionary, zeroed byte window, start of
// text reachable, no request pending. Stored words are undefined until written.
`default_nettype none
module word_break_feasibility #(
	parameter int MAX_WORD_LEN = 8,
	parameter int DICT_WORDS   = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// request channel
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                command,
	input  wire logic [63:0]               word_bytes,
	input  wire logic [3:0]                word_length,
	input  wire logic [7:0]                text_byte,
	input  wire logic                      final_byte,
	// result channel
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           prefix_breakable,
	output logic                           answer_valid,
	output logic [1:0]                     status
);
	import wbf_pkg::*;

	localparam int WW    = 8 * MAX_WORD_LEN;
	localparam int CNT_W = $clog2(DICT_WORDS + 1);
	localparam int SC_W  = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;

	state_t            state_q, state_d;
	cell_ctrl_t        ctrl;
	cmd_t              cmd;
	logic              in_fire;
	logic              out_free;
	logic              finish_fire;
	logic              add_ok;
	status_t           add_status;
	logic [63:0]       len_mask;
	logic [WW-1:0]     load_word;

	logic [CNT_W-1:0]  count_q;      // words stored
	logic [SC_W-1:0]   scan_q;       // cells passed by the hit carry
	logic [WW-1:0]     window_q;     // newest byte at the top
	logic [MAX_WORD_LEN-1:0] reach_q; // bit k: prefix k bytes back reachable
	logic              fin_q;

	logic              out_valid_q;
	logic              breakable_q;
	logic              answer_q;
	status_t           status_q;

	logic [DICT_WORDS-1:0] hit;
	logic [DICT_WORDS-1:0] cell_en;
	logic [DICT_WORDS-1:0] cell_load;

	assign cmd      = cmd_t'(command);
	assign out_free = !out_valid_q || !out_stall;

	// ---------------------------------------------------------------
	// Sequencer: idle takes requests, scan ripples the match carry down
	// the cell row, finish posts the text-byte result once the output
	// register can take it.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && cmd == CMD_TEXT) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (scan_q == SC_W'(DICT_WORDS - 1)) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		ctrl.flush  = 1'b0;
		ctrl.scan   = 1'b0;
		finish_fire = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall   = !out_free;
				ctrl.flush = 1'b1;
			end
			S_SCAN: begin
				ctrl.scan = 1'b1;
			end
			S_FINISH: begin
				finish_fire = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign in_fire = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (ctrl.scan) begin
			scan_q <= scan_q + SC_W'(1);
		end else begin
			scan_q <= '0;
		end
	end

	// ---------------------------------------------------------------
	// Dictionary add: length check first, then capacity.
	// ---------------------------------------------------------------
	always_comb begin
		add_ok     = 1'b0;
		add_status = ST_OK;
		if (word_length == '0 || word_length > LEN_W'(MAX_WORD_LEN)) begin
			add_status = ST_BAD_LEN;
		end else if (count_q >= CNT_W'(DICT_WORDS)) begin
			add_status = ST_FULL;
		end else begin
			add_ok = 1'b1;
		end
	end

	always_comb begin
		len_mask = '0;
		for (int b = 0; b < 8; b++) begin
			if (b < int'(word_length)) len_mask[8*b +: 8] = 8'hFF;
		end
	end

	assign load_word = WW'(word_bytes & len_mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_fire) begin
			case (cmd)
				CMD_CLEAR: count_q <= '0;
				CMD_ADD:   if (add_ok) count_q <= count_q + CNT_W'(1);
				default:   count_q <= count_q;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Text state: the byte shifts in on accept; the reach window takes
	// the row's answer when the result is posted.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			reach_q  <= MAX_WORD_LEN'(1);
			fin_q    <= 1'b0;
		end else if (in_fire && cmd == CMD_START) begin
			window_q <= '0;
			reach_q  <= MAX_WORD_LEN'(1);
		end else if (in_fire && cmd == CMD_TEXT) begin
			window_q <= (window_q >> 8) | (WW'(text_byte) << (WW - 8));
			fin_q    <= final_byte;
		end else if (finish_fire) begin
			reach_q <= (reach_q << 1) | MAX_WORD_LEN'(hit[DICT_WORDS-1]);
		end
	end

	// ---------------------------------------------------------------
	// Cell row: one stored word per cell, the hit carry ORs along it.
	// ---------------------------------------------------------------
	for (genvar i = 0; i < DICT_WORDS; i++) begin : g_cell
		assign cell_en[i]   = count_q > CNT_W'(i);
		assign cell_load[i] = in_fire && cmd == CMD_ADD && add_ok
		                      && count_q == CNT_W'(i);

		wbf_cell #(
			.MAX_WORD_LEN(MAX_WORD_LEN)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.enable    (cell_en[i]),
			.load      (cell_load[i]),
			.load_word (load_word),
			.load_len  (word_length),
			.window    (window_q),
			.reach     (reach_q),
			.hit_in    ((i == 0) ? 1'b0 : hit[(i == 0) ? 0 : i-1]),
			.hit_out   (hit[i])
		);
	end

	// ---------------------------------------------------------------
	// Output register: a result that leaves this cycle makes room for
	// the next request; a stalled one holds the request side off.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_fire || (in_fire && cmd != CMD_TEXT)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_fire) begin
			breakable_q <= hit[DICT_WORDS-1];
			answer_q    <= fin_q;
			status_q    <= ST_OK;
		end else if (in_fire && cmd != CMD_TEXT) begin
			breakable_q <= (cmd == CMD_START);
			answer_q    <= (cmd == CMD_START) && final_byte;
			status_q    <= (cmd == CMD_ADD) ? add_status : ST_OK;
		end
	end

	assign out_valid        = out_valid_q;
	assign prefix_breakable = breakable_q;
	assign answer_valid     = answer_q;
	assign status           = status_q;

endmodule
`default_nettype wire

FILE: bench/wbf_checker.sv
`timescale 1ns / 1ps

// Watches both channels of word_break_feasibility, predicts each result
// and compares it with what comes out.
module wbf_checker #(
	parameter int MAX_WORD_LEN = 8,
	parameter int DICT_WORDS   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  command,
	input  logic [63:0] word_bytes,
	input  logic [3:0]  word_length,
	input  logic [7:0]  text_byte,
	input  logic        final_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        prefix_breakable,
	input  logic        answer_valid,
	input  logic [1:0]  status,
	output int          outstanding,
	output int          mismatch_count
);
	import wbf_pkg::*;

	typedef struct packed {
		logic    breakable;
		logic    whole;
		status_t status;
	} verdict_t;

	// shadow dictionary and text state
	logic [63:0] lex_word [DICT_WORDS];
	logic [3:0]  lex_len  [DICT_WORDS];
	int          word_total = 0;
	logic [63:0] window     = '0;  // newest byte in 63:56
	logic [7:0]  reach      = 8'd1;  // bit k: prefix k bytes back splits

	verdict_t pending_verdicts[$];
	verdict_t want;
	int       waiting    = 0;
	int       fail_tally = 0;

	assign outstanding    = waiting;
	assign mismatch_count = fail_tally;

	function automatic verdict_t segment_step(cmd_t op, logic [63:0] word,
			logic [3:0] wlen, logic [7:0] tbyte, logic fin);
		verdict_t v;
		logic     hit;
		int       len;
		v = '{breakable: 1'b0, whole: 1'b0, status: ST_OK};
		case (op)
			CMD_CLEAR: word_total = 0;
			CMD_ADD: begin
				if (wlen == 4'd0 || wlen > MAX_WORD_LEN)
					v.status = ST_BAD_LEN;
				else if (word_total >= DICT_WORDS)
					v.status = ST_FULL;
				else begin
					lex_word[word_total] = word & ((wlen == 4'd8) ? {64{1'b1}}
						: ((64'd1 << (8 * wlen)) - 64'd1));
					lex_len[word_total] = wlen;
					word_total++;
				end
			end
			CMD_START: begin
				window = '0;
				reach = 8'd1;
				v.breakable = 1'b1;
				v.whole = fin;
			end
			default: begin
				window = {tbyte, window[63:8]};
				hit = 1'b0;
				for (int i = 0; i < word_total; i++) begin
					len = lex_len[i];
					if (!hit && reach[len - 1] && (window >> (8 * (8 - len))) == lex_word[i])
						hit = 1'b1;
				end
				reach = {reach[6:0], hit};
				v.breakable = hit;
				v.whole = fin;
			end
		endcase
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_total = 0;
			window = '0;
			reach = 8'd1;
			pending_verdicts.delete();
			waiting <= 0;
		end else begin
			// retire first so a result never meets its own request
			if (out_valid && !out_stall) begin
				if (pending_verdicts.size() == 0) begin
					$error("unexpected result: prefix_breakable %0d answer_valid %0d status %0d",
						prefix_breakable, answer_valid, status);
					fail_tally++;
				end else begin
					want = pending_verdicts.pop_front();
					if (prefix_breakable !== want.breakable) begin
						$error("prefix_breakable: expected %0d, got %0d", want.breakable,
							prefix_breakable);
						fail_tally++;
					end
					if (answer_valid !== want.whole) begin
						$error("answer_valid: expected %0d, got %0d", want.whole, answer_valid);
						fail_tally++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_tally++;
					end
				end
			end
			if (in_valid && !in_stall)
				pending_verdicts.insert(pending_verdicts.size(),
					segment_step(cmd_t'(command), word_bytes, word_length, text_byte,
						final_byte));
			waiting <= pending_verdicts.size();
		end
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for word_break_feasibility. All prediction and
// comparison lives in wbf_checker; this module only drives requests,
// throttles the result side and reports the outcome.
module tb;
	import wbf_pkg::*;

	localparam int MAX_WORD_LEN = 8;
	localparam int DICT_WORDS   = 64;
	localparam int REQUEST_GOAL = 1650;

	// lowercase letters used to build words that overlap a lot
	localparam logic [7:0] LTR_A = 8'h61;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [1:0]  command     = CMD_CLEAR;
	logic [63:0] word_bytes  = '0;
	logic [3:0]  word_length = '0;
	logic [7:0]  text_byte   = '0;
	logic        final_byte  = 1'b0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic        prefix_breakable;
	logic        answer_valid;
	logic [1:0]  status;
	int          outstanding;
	int          mismatch_count;

	// stimulus-side copy of the words that went in, only to build texts
	// that actually segment; exactness here does not matter
	logic [63:0] lexicon_words[$];
	logic [3:0]  lexicon_lens[$];

	int requests_sent = 0;
	int burst_left    = 0;

	// result-side throttle
	int stall_mode  = 0;
	int stall_phase = 0;
	int stall_run   = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	word_break_feasibility #(
		.MAX_WORD_LEN(MAX_WORD_LEN),
		.DICT_WORDS  (DICT_WORDS)
	) dut (.*);

	wbf_checker #(
		.MAX_WORD_LEN(MAX_WORD_LEN),
		.DICT_WORDS  (DICT_WORDS)
	) checker_i (.*);

	// Receiver: works in phases, each either never stalling,
	// stalling at random, or alternating runs of stall and no stall.
	always @(posedge clk) begin
		if (stall_phase == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_phase <= $urandom_range(50, 400);
		end else
			stall_phase <= stall_phase - 1;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			default: begin
				if (stall_run == 0) begin
					out_stall <= ~out_stall;
					stall_run <= $urandom_range(1, 12);
				end else
					stall_run <= stall_run - 1;
			end
		endcase
	end

	// One request; returns at the edge where it is taken. Bursts of random
	// length are separated by random gaps, sometimes none at all.
	task automatic send_request(input cmd_t op, input logic [63:0] word,
			input logic [3:0] wlen, input logic [7:0] tbyte, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			case ($urandom_range(0, 9))
				0, 1, 2: gap = 0;
				3:       gap = $urandom_range(30, 80);
				default: gap = $urandom_range(1, 12);
			endcase
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= op;
		word_bytes <= word;
		word_length <= wlen;
		text_byte <= tbyte;
		final_byte <= fin;
		do @(posedge clk); while (in_stall);
		requests_sent++;
		// keep the stimulus lexicon roughly in step with the block
		if (op == CMD_CLEAR) begin
			lexicon_words.delete();
			lexicon_lens.delete();
		end else if (op == CMD_ADD && wlen != 4'd0 && wlen <= MAX_WORD_LEN
				&& lexicon_words.size() < DICT_WORDS) begin
			lexicon_words.insert(lexicon_words.size(), word);
			lexicon_lens.insert(lexicon_lens.size(), wlen);
		end
	endtask

	// Pause the sender until every result is back. The count from the
	// checker is registered, hence the extra edge before looking at it.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic send_text_byte(input logic [7:0] tbyte, input logic fin);
		send_request(CMD_TEXT, {$urandom, $urandom}, 4'($urandom), tbyte, fin);
	endtask

	// random garbage above the word, letters (mostly a..c) in the low n bytes
	function automatic logic [63:0] spell_word(int n);
		logic [63:0] w;
		w = {$urandom, $urandom};
		for (int b = 0; b < n; b++)
			w[8 * b +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom)
				: LTR_A + 8'($urandom_range(0, 2));
		return w;
	endfunction

	task automatic add_word();
		int n;
		// mostly legal lengths; now and then anything the field can hold
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
		send_request(CMD_ADD, spell_word(n > 8 ? 8 : n), 4'(n), 8'($urandom),
			1'($urandom));
	endtask

	// Text made of lexicon words, with the odd random byte mixed in.
	// The last byte carries final_byte when closed is set.
	task automatic spell_text(input int pieces, input bit closed);
		logic [7:0] text_q[$];
		int         k;
		for (int p = 0; p < pieces; p++) begin
			if (lexicon_words.size() == 0 || $urandom_range(0, 9) == 0)
				text_q.insert(text_q.size(), 8'($urandom));
			else begin
				k = $urandom_range(0, lexicon_words.size() - 1);
				for (int b = 0; b < lexicon_lens[k]; b++)
					text_q.insert(text_q.size(), lexicon_words[k][8 * b +: 8]);
			end
		end
		foreach (text_q[i])
			send_text_byte(text_q[i], closed && i == text_q.size() - 1);
	endtask

	task automatic send_noise();
		send_request(cmd_t'($urandom_range(0, 3)), {$urandom, $urandom},
			4'($urandom_range(0, 15)), 8'($urandom), 1'($urandom));
	endtask

	initial begin
		int kind;
		int episode;
		episode = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed ----
		// byte straight after reset: empty dictionary, nothing matches
		send_text_byte(LTR_A, 1'b0);
		// bad lengths: zero, just above the limit, all ones
		send_request(CMD_ADD, 64'h61, 4'd0, 8'h00, 1'b0);
		send_request(CMD_ADD, 64'h6161_6161_6161_6161, 4'd9, 8'h00, 1'b0);
		send_request(CMD_ADD, {64{1'b1}}, 4'd15, 8'hFF, 1'b1);
		// "a" with junk above its one byte, a full eight-byte word, "ab",
		// and a duplicate "a"
		send_request(CMD_ADD, 64'hFFFF_FFFF_FFFF_FF61, 4'd1, 8'h00, 1'b0);
		send_request(CMD_ADD, 64'h6867_6665_6463_6261, 4'd8, 8'h00, 1'b0);
		send_request(CMD_ADD, 64'hA5A5_A5A5_A5A5_6261, 4'd2, 8'h00, 1'b0);
		send_request(CMD_ADD, 64'h0000_0000_0000_0061, 4'd1, 8'h00, 1'b0);
		// empty text answered on start
		send_request(CMD_START, '0, '0, '0, 1'b1);
		send_request(CMD_START, {64{1'b1}}, 4'hF, 8'hFF, 1'b0);
		// "abcdefgh": the long word reaches back to the start of text
		for (int i = 0; i < 8; i++)
			send_text_byte(LTR_A + 8'(i), i == 7);
		// bytes after a final byte just extend the text
		send_text_byte(LTR_A, 1'b0);
		// clear keeps the text state but empties the dictionary
		send_request(CMD_CLEAR, {64{1'b1}}, 4'hF, 8'hFF, 1'b1);
		send_text_byte(LTR_A, 1'b0);
		send_text_byte(8'hFF, 1'b0);
		send_text_byte(8'h00, 1'b1);

		// ---- random episodes ----
		while (requests_sent < REQUEST_GOAL) begin
			// first episode always clears and refills the dictionary, usually to capacity or past it
			kind = (episode == 0) ? 1 : $urandom_range(0, 19);
			case (kind)
				0, 2: repeat ($urandom_range(1, 6)) send_noise();
				1: begin
					send_request(CMD_CLEAR, {$urandom, $urandom}, 4'($urandom), 8'($urandom),
						1'($urandom));
					repeat ($urandom_range(62, 70)) begin
						send_request(CMD_ADD, spell_word(8), 4'($urandom_range(1, 8)),
							8'($urandom), 1'($urandom));
					end
					send_request(CMD_START, '0, '0, '0, 1'b0);
					spell_text($urandom_range(1, 6), 1'b1);
				end
				default: begin
					if ($urandom_range(0, 1) == 0)
						send_request(CMD_CLEAR, {$urandom, $urandom}, 4'($urandom),
							8'($urandom), 1'($urandom));
					repeat ($urandom_range(1, 8)) add_word();
					if ($urandom_range(0, 15) == 0)
						send_request(CMD_START, {$urandom, $urandom}, 4'($urandom),
							8'($urandom), 1'b1);
					else begin
						send_request(CMD_START, {$urandom, $urandom}, 4'($urandom),
							8'($urandom), 1'b0);
						spell_text($urandom_range(1, 6), $urandom_range(0, 5) != 0);
					end
					if ($urandom_range(0, 9) == 0)
						send_noise();
				end
			endcase
			if (episode == 0 || $urandom_range(0, 7) == 0)
				wait_for_results();
			episode++;
		end

		// drain, then let any late activity show up
		wait_for_results();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// hang guard
	initial begin
		#20_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
